### rtl/core/lie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lie_pkg
// Shared types and constants of the console line editor: character codes,
// field widths, the command word passed from the front end to the back end,
// and the step encoding of the back-end sequencer.
// ----------------------------------------------------------------------------
package lie_pkg;

    // Field widths of the ports.
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 7;
    localparam int LEN_W  = 7;

    // Position width: holds any store position up to 255, which covers the
    // largest line limit plus the two trailing bytes.
    localparam int POS_W  = 8;

    // Depth of the command queue between front and back end.
    localparam int QUEUE_DEPTH = 2;

    // Character codes.
    localparam logic [BYTE_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;

    // Input opcodes.
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Command kinds produced by the front end.
    typedef enum logic [1:0] {
        CMD_READ,
        CMD_CHAR,
        CMD_LINE_END,
        CMD_ERASE
    } t_cmd_kind;

    // One queued command. For reads, pos carries the read index.
    typedef struct packed {
        t_cmd_kind          kind;
        logic [BYTE_W-1:0]  key;
        logic [POS_W-1:0]   pos;
    } t_cmd;

    // Back-end sequencer steps.
    typedef enum logic [1:0] {
        STEP_FIRST,
        STEP_SECOND,
        STEP_THIRD
    } t_step;

endpackage

### rtl/core/lie_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lie_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/lie_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lie_front
// Front end: accepts input words, tracks the write position and classifies
// each word into a command for the back end.
// ----------------------------------------------------------------------------
module lie_front
    import lie_pkg::*;
#(
    parameter int LINE_LIMIT = 78
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_opcode,
    input  logic [BYTE_W-1:0] i_key_byte,
    input  logic [IDX_W-1:0]  i_read_index,
    input  logic              i_queue_full,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] pos_next;
    logic             accept;
    logic             drop;

    assign accept   = i_valid && !i_queue_full;
    assign pos_next = r_pos + POS_W'(1);

    // Classify the word and compute the next write position.
    always_comb begin
        n_pos       = r_pos;
        drop        = 1'b0;
        o_cmd.kind  = CMD_READ;
        o_cmd.key   = i_key_byte;
        o_cmd.pos   = POS_W'(i_read_index);
        if (i_opcode == OP_KEY) begin
            o_cmd.pos = r_pos;
            if (i_key_byte == CHAR_BS) begin
                o_cmd.kind = CMD_ERASE;
                if (r_pos == '0) begin
                    drop = 1'b1;
                end else begin
                    n_pos = r_pos - POS_W'(1);
                end
            end else if (i_key_byte == CHAR_CR || pos_next >= POS_W'(LINE_LIMIT)) begin
                o_cmd.kind = CMD_LINE_END;
                n_pos      = '0;
            end else begin
                o_cmd.kind = CMD_CHAR;
                n_pos      = pos_next;
            end
        end
    end

    assign o_push = accept && !drop;

    // Write position register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            r_pos <= n_pos;
        end
    end

endmodule

### rtl/core/lie_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lie_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module lie_queue
    import lie_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

### rtl/core/lie_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lie_back
// Back end: steps through each command, writes the line store, reads it for
// reads and fills the output register one word per cycle when not stalled.
// ----------------------------------------------------------------------------
module lie_back
    import lie_pkg::*;
#(
    parameter int BUF_DEPTH = 80
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_echo_byte,
    output logic [BYTE_W-1:0] o_read_data,
    output logic              o_is_last,
    output logic              o_line_done,
    output logic [LEN_W-1:0]  o_line_length
);

    localparam int AW   = $clog2(BUF_DEPTH);
    localparam int PX_W = POS_W + 1;

    t_step             r_step;
    t_step             n_step;
    logic              r_valid_out;
    logic [BYTE_W-1:0] r_echo;
    logic [BYTE_W-1:0] r_rdata;
    logic              r_last;
    logic              r_done;
    logic [LEN_W-1:0]  r_len;
    logic [BUF_DEPTH-1:0] r_entry_ok;
    logic              r_rd_ok;

    logic [PX_W-1:0]   pos_x;
    logic [PX_W-1:0]   pos_p1;
    logic [PX_W-1:0]   pos_p2;
    logic              out_free;
    logic              want_emit;
    logic              fire;
    logic              rd_issue;
    logic              rd_in_range;
    logic              sel_read;
    logic [BYTE_W-1:0] e_echo;
    logic              e_last;
    logic              e_done;
    logic              wr;
    logic [PX_W-1:0]   w_addr;
    logic [BYTE_W-1:0] w_data;
    logic              we;
    logic [BYTE_W-1:0] ram_rdata;

    assign pos_x    = PX_W'(i_cmd.pos);
    assign pos_p1   = pos_x + PX_W'(1);
    assign pos_p2   = pos_x + PX_W'(2);
    assign out_free = !r_valid_out || !i_stall;

    // Step outputs: what the current step emits and writes.
    always_comb begin
        want_emit = 1'b0;
        rd_issue  = 1'b0;
        sel_read  = 1'b0;
        e_echo    = CHAR_NUL;
        e_last    = 1'b0;
        e_done    = 1'b0;
        wr        = 1'b0;
        w_addr    = pos_x;
        w_data    = i_cmd.key;
        case (i_cmd.kind)
            CMD_READ: begin
                if (r_step == STEP_FIRST) begin
                    rd_issue = i_cmd_valid;
                end else begin
                    want_emit = 1'b1;
                    sel_read  = 1'b1;
                    e_last    = 1'b1;
                end
            end
            CMD_CHAR: begin
                want_emit = 1'b1;
                e_echo    = i_cmd.key;
                e_last    = 1'b1;
                wr        = 1'b1;
            end
            CMD_LINE_END: begin
                want_emit = 1'b1;
                e_done    = 1'b1;
                wr        = 1'b1;
                case (r_step)
                    STEP_FIRST: begin
                        e_echo = i_cmd.key;
                    end
                    STEP_SECOND: begin
                        e_echo = CHAR_CR;
                        w_addr = pos_p1;
                        w_data = CHAR_LF;
                    end
                    default: begin
                        e_echo = CHAR_LF;
                        w_addr = pos_p2;
                        w_data = CHAR_NUL;
                        e_last = 1'b1;
                    end
                endcase
            end
            default: begin
                want_emit = 1'b1;
                case (r_step)
                    STEP_FIRST:  e_echo = CHAR_BS;
                    STEP_SECOND: e_echo = CHAR_SPACE;
                    default: begin
                        e_echo = CHAR_BS;
                        e_last = 1'b1;
                    end
                endcase
            end
        endcase
    end

    assign fire  = i_cmd_valid && want_emit && out_free;
    assign o_pop = fire && e_last;
    assign we    = fire && wr && (w_addr < PX_W'(BUF_DEPTH));

    // Step sequencing.
    always_comb begin
        n_step = r_step;
        if (rd_issue) begin
            n_step = STEP_SECOND;
        end else if (fire) begin
            if (e_last) begin
                n_step = STEP_FIRST;
            end else begin
                case (r_step)
                    STEP_FIRST:  n_step = STEP_SECOND;
                    STEP_SECOND: n_step = STEP_THIRD;
                    default:     n_step = STEP_FIRST;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_FIRST;
        end else begin
            r_step <= n_step;
        end
    end

    // Line store.
    lie_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (w_addr[AW-1:0]),
        .i_wdata (w_data),
        .i_re    (rd_issue),
        .i_raddr (pos_x[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Written flags: an entry never written reads as zero.
    assign rd_in_range = pos_x < PX_W'(BUF_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_ok <= '0;
            r_rd_ok    <= 1'b0;
        end else begin
            if (we) begin
                r_entry_ok[w_addr[AW-1:0]] <= 1'b1;
            end
            if (rd_issue) begin
                r_rd_ok <= rd_in_range && r_entry_ok[pos_x[AW-1:0]];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_out <= 1'b0;
        end else if (fire) begin
            r_valid_out <= 1'b1;
        end else if (!i_stall) begin
            r_valid_out <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_echo  <= e_echo;
            r_rdata <= (sel_read && r_rd_ok) ? ram_rdata : CHAR_NUL;
            r_last  <= e_last;
            r_done  <= e_done;
            r_len   <= e_done ? pos_p1[LEN_W-1:0] : '0;
        end
    end

    assign o_valid       = r_valid_out;
    assign o_echo_byte   = r_echo;
    assign o_read_data   = r_rdata;
    assign o_is_last     = r_last;
    assign o_line_done   = r_done;
    assign o_line_length = r_len;

endmodule

### rtl/core/line_input_editor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_input_editor
// Each word passes the queue stage, the store read for reads, and the output
// register. Results leave the output register at one word per cycle while
// i_stall is low; an ordinary key gives one word, a line end or backspace
// three, and a read one word after a registered store read.
// Reset clears the write position, queue and output; the line store reads as
// all zero through per-entry written flags, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module line_input_editor
    import lie_pkg::*;
#(
    parameter int BUF_DEPTH  = 80,
    parameter int LINE_LIMIT = 78
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_opcode,
    input  logic [BYTE_W-1:0] i_key_byte,
    input  logic [IDX_W-1:0]  i_read_index,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_echo_byte,
    output logic [BYTE_W-1:0] o_read_data,
    output logic              o_is_last,
    output logic              o_line_done,
    output logic [LEN_W-1:0]  o_line_length
);

    logic queue_full;
    logic push;
    t_cmd front_cmd;
    logic pop;
    logic head_valid;
    t_cmd head_cmd;

    assign o_stall = queue_full;

    // Front end: classification and write position.
    lie_front #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_opcode     (i_opcode),
        .i_key_byte   (i_key_byte),
        .i_read_index (i_read_index),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    // Command queue.
    lie_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    // Back end: store access and result words.
    lie_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (head_valid),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_echo_byte   (o_echo_byte),
        .o_read_data   (o_read_data),
        .o_is_last     (o_is_last),
        .o_line_done   (o_line_done),
        .o_line_length (o_line_length)
    );

endmodule
